@@ rtl/core/sawarq_pkg.sv @@
// ----------------------------------------------------------------------------
// sawarq_pkg
// Shared types and constants of the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
package sawarq_pkg;

    // fixed field widths
    localparam int PAYLOAD_MAX_BYTES = 20;
    localparam int PAYLOAD_MAX_W     = 8 * PAYLOAD_MAX_BYTES;
    localparam int SUM_W             = 13;   // signed sum of up to 20 signed bytes
    localparam int SEQ_W             = 32;
    localparam int TIMER_W           = 16;
    localparam int REQ_W             = 2;
    localparam int S_TDATA_W         = 224;
    localparam int M_TDATA_W         = 240;

    // request codes on s_tuser
    localparam logic [REQ_W-1:0] REQ_MSG    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd2;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_MSG,
        CMD_ACK,
        CMD_EXPIRE
    } cmd_kind_t;

    // result action codes on m_tuser
    typedef enum logic [1:0] {
        ACT_TRANSMIT,
        ACT_STOP,
        ACT_DROP
    } action_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [PAYLOAD_MAX_W-1:0] payload;
        logic [SUM_W-1:0]         bsum;
        logic [SEQ_W-1:0]         ack_number;
    } cmd_t;

    // sign-extend a byte sum to sequence width
    function automatic logic [SEQ_W-1:0] sum_ext(input logic [SUM_W-1:0] s);
        return {{(SEQ_W - SUM_W){s[SUM_W-1]}}, s};
    endfunction

    // sign-extend one byte to sum width
    function automatic logic [SUM_W-1:0] byte_ext(input logic [7:0] b);
        return {{(SUM_W - 8){b[7]}}, b};
    endfunction

endpackage

@@ rtl/core/sawarq_ram.sv @@
// ----------------------------------------------------------------------------
// sawarq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sawarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/sawarq_front.sv @@
// ----------------------------------------------------------------------------
// sawarq_front
// Accepts input beats, masks the payload, sums its bytes and checks
// acknowledgement checksums, then hands commands to the queue.
// ----------------------------------------------------------------------------
module sawarq_front #(
    parameter int PAYLOAD_BYTES = 20
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sawarq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [sawarq_pkg::REQ_W-1:0]      s_tuser,
    input  logic                              q_full,
    output logic                              push_valid,
    output sawarq_pkg::cmd_t                  push_cmd
);
    import sawarq_pkg::*;

    logic [PAYLOAD_MAX_W-1:0] payload;
    logic [SUM_W-1:0]         gsum [5];
    logic [SUM_W-1:0]         total;
    logic [SEQ_W-1:0]         ack_number;
    logic [SEQ_W-1:0]         ack_check;
    logic                     ack_ok;
    logic                     keep;

    assign ack_number = s_tdata[191:160];
    assign ack_check  = s_tdata[223:192];

    // zero bytes beyond the payload length
    always_comb begin
        for (int i = 0; i < PAYLOAD_MAX_BYTES; i++) begin
            payload[i*8 +: 8] = (i < PAYLOAD_BYTES) ? s_tdata[i*8 +: 8] : 8'h00;
        end
    end

    // byte sum as a two-level tree of groups of four
    always_comb begin
        for (int g = 0; g < 5; g++) begin
            gsum[g] = byte_ext(payload[(g*4)*8 +: 8])     + byte_ext(payload[(g*4+1)*8 +: 8])
                    + byte_ext(payload[(g*4+2)*8 +: 8]) + byte_ext(payload[(g*4+3)*8 +: 8]);
        end
        total = gsum[0] + gsum[1] + gsum[2] + gsum[3] + gsum[4];
    end

    assign ack_ok = ((ack_number + sum_ext(total)) == ack_check);

    // classify the request
    always_comb begin
        push_cmd.payload    = payload;
        push_cmd.bsum       = total;
        push_cmd.ack_number = ack_number;
        unique case (s_tuser)
            REQ_MSG: begin
                push_cmd.kind = CMD_MSG;
                keep          = 1'b1;
            end
            REQ_ACK: begin
                push_cmd.kind = CMD_ACK;
                keep          = ack_ok;
            end
            REQ_EXPIRE: begin
                push_cmd.kind = CMD_EXPIRE;
                keep          = 1'b1;
            end
            default: begin
                push_cmd.kind = CMD_MSG;
                keep          = 1'b0;
            end
        endcase
    end

    assign s_tready   = !q_full;
    assign push_valid = s_tvalid && !q_full && keep;

endmodule

@@ rtl/core/sawarq_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// sawarq_cmd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sawarq_cmd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  sawarq_pkg::cmd_t push_cmd,
    output logic             full,
    output logic             pop_valid,
    output sawarq_pkg::cmd_t pop_cmd,
    input  logic             pop_ready
);
    import sawarq_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/sawarq_back.sv @@
// ----------------------------------------------------------------------------
// sawarq_back
// Carries out commands: owns the in-flight packet, the pending queue and
// the sequence number, and drives the registered result channel.
// ----------------------------------------------------------------------------
module sawarq_back #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_BYTES = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmd_valid,
    input  sawarq_pkg::cmd_t                 cmd,
    output logic                             cmd_ready,
    input  logic [sawarq_pkg::TIMER_W-1:0]   interval,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sawarq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                       m_tuser
);
    import sawarq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = 8 * PAYLOAD_BYTES;
    localparam int RW = PW + SUM_W;

    // state
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     inflight_reg, inflight_next;
    logic [PAYLOAD_MAX_W-1:0] infl_pay_reg, infl_pay_next;
    logic [SUM_W-1:0]         infl_sum_reg, infl_sum_next;
    logic [SEQ_W-1:0]         seq_reg, seq_next;
    logic                     use_fwd_reg, use_fwd_next;
    logic [RW-1:0]            fwd_reg;

    // result register
    logic                     m_valid_reg, m_valid_next;
    action_t                  act_reg;
    logic [SEQ_W-1:0]         out_seq_reg;
    logic [SEQ_W-1:0]         out_chk_reg;
    logic [PAYLOAD_MAX_W-1:0] out_pay_reg;
    logic [TIMER_W-1:0]       out_tmr_reg;

    // result computed this cycle
    logic                     emit;
    action_t                  act;
    logic [SEQ_W-1:0]         out_seq;
    logic [SEQ_W-1:0]         out_chk;
    logic [PAYLOAD_MAX_W-1:0] out_pay;
    logic [TIMER_W-1:0]       out_tmr;

    logic                     fire;
    logic                     wr_en;
    logic [RW-1:0]            wr_data;
    logic [RW-1:0]            ram_rd;
    logic [RW-1:0]            head_data;
    logic [PAYLOAD_MAX_W-1:0] head_pay;
    logic [SUM_W-1:0]         head_sum;
    logic [SEQ_W-1:0]         seq_plus;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cmd_ready = !m_valid_reg || m_tready;
    assign fire      = cmd_valid && cmd_ready;
    assign wr_data   = {cmd.bsum, cmd.payload[PW-1:0]};
    assign head_data = use_fwd_reg ? fwd_reg : ram_rd;
    assign head_pay  = PAYLOAD_MAX_W'(head_data[PW-1:0]);
    assign head_sum  = head_data[PW +: SUM_W];
    assign seq_plus  = seq_reg + 1'b1;

    // pending message store, read address tracks the next head
    sawarq_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_pending (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (ram_rd)
    );

    // command execution
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        inflight_next = inflight_reg;
        infl_pay_next = infl_pay_reg;
        infl_sum_next = infl_sum_reg;
        seq_next      = seq_reg;
        wr_en         = 1'b0;
        emit          = 1'b0;
        act           = ACT_TRANSMIT;
        out_seq       = '0;
        out_chk       = '0;
        out_pay       = '0;
        out_tmr       = '0;
        if (fire) begin
            unique case (cmd.kind)
                CMD_MSG: begin
                    if (!inflight_reg) begin
                        inflight_next = 1'b1;
                        infl_pay_next = cmd.payload;
                        infl_sum_next = cmd.bsum;
                        emit          = 1'b1;
                        out_seq       = seq_reg;
                        out_chk       = seq_reg + sum_ext(cmd.bsum);
                        out_pay       = cmd.payload;
                        out_tmr       = interval;
                    end else if (count_reg == CW'(QUEUE_DEPTH)) begin
                        emit = 1'b1;
                        act  = ACT_DROP;
                    end else begin
                        wr_en      = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_ACK: begin
                    if (inflight_reg && (cmd.ack_number == seq_reg)) begin
                        seq_next = seq_plus;
                        emit     = 1'b1;
                        if (count_reg != '0) begin
                            infl_pay_next = head_pay;
                            infl_sum_next = head_sum;
                            head_next     = ptr_inc(head_reg);
                            count_next    = count_reg - 1'b1;
                            out_seq       = seq_plus;
                            out_chk       = seq_plus + sum_ext(head_sum);
                            out_pay       = head_pay;
                            out_tmr       = interval;
                        end else begin
                            inflight_next = 1'b0;
                            act           = ACT_STOP;
                        end
                    end
                end
                CMD_EXPIRE: begin
                    if (inflight_reg) begin
                        emit    = 1'b1;
                        out_seq = seq_reg;
                        out_chk = seq_reg + sum_ext(infl_sum_reg);
                        out_pay = infl_pay_reg;
                        out_tmr = interval;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // forward a write that lands on the slot being read
    assign use_fwd_next = wr_en && (tail_reg == head_next);

    // result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd_ready) begin
            m_valid_next = emit;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            inflight_reg <= 1'b0;
            seq_reg      <= '0;
            use_fwd_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            inflight_reg <= inflight_next;
            seq_reg      <= seq_next;
            use_fwd_reg  <= use_fwd_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        infl_pay_reg <= infl_pay_next;
        infl_sum_reg <= infl_sum_next;
        if (wr_en) begin
            fwd_reg <= wr_data;
        end
        if (cmd_ready && emit) begin
            act_reg     <= act;
            out_seq_reg <= out_seq;
            out_chk_reg <= out_chk;
            out_pay_reg <= out_pay;
            out_tmr_reg <= out_tmr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = act_reg;
    assign m_tdata  = {out_tmr_reg, out_pay_reg, out_chk_reg, out_seq_reg};

endmodule

@@ rtl/core/stop_and_wait_arq_sender_unit.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_unit
// Sender side of a stop-and-wait ARQ link: messages, acknowledgements and
// timer expiries in, transmit / stop-timer / drop results out.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while the command queue has room
// and gives at most one result per beat. A beat waits in the two-entry
// command queue behind the checksum front end; its result then waits in the
// result register of the execution back end. Sustained rate is one beat per
// cycle while the result channel is not stalled; the pending queue has a
// single RAM port pair (one write, one registered read whose address follows
// the queue head) and needs no clearing after reset. The retransmit interval
// register may be written at any time the block is idle and is always ready.
module stop_and_wait_arq_sender_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_BYTES = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input: tdata = payload_word0, payload_word1, payload_word2,
    //        ack_number, ack_check; tuser = req_type
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sawarq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [sawarq_pkg::REQ_W-1:0]     s_tuser,
    // result: tdata = tx_sequence, tx_checksum, tx_word0, tx_word1,
    //         tx_word2, timer_value; tuser = action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sawarq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                       m_tuser,
    // retransmit_interval write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sawarq_pkg::TIMER_W-1:0]   cfg_data
);
    import sawarq_pkg::*;

    logic [TIMER_W-1:0] interval_reg;
    logic               q_full;
    logic               push_valid;
    cmd_t               push_cmd;
    logic               pop_valid;
    cmd_t               pop_cmd;
    logic               pop_ready;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= TIMER_W'(20);
        end else if (cfg_valid) begin
            interval_reg <= cfg_data;
        end
    end

    // accept and classify
    sawarq_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    sawarq_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // execute
    sawarq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .interval  (interval_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
